// ----- rtl/nle_pkg.sv -----
// Package for the numeric literal encoder: shared types, character codes,
// register indexes and reset values. No dependencies.
package nle_pkg;

	localparam int CharW = 8;
	localparam int AccW  = 32;
	localparam int CfgIdxW = 2;

	// Configuration register indexes
	localparam logic [CfgIdxW-1:0] CFG_SHORT_OP = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_WORD_OP  = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_LONG_OP  = 2'd2;

	// Opcode reset values
	localparam logic [7:0] SHORT_OP_RST = 8'd1;
	localparam logic [7:0] WORD_OP_RST  = 8'd2;
	localparam logic [7:0] LONG_OP_RST  = 8'd3;

	// Characters of interest
	localparam logic [CharW-1:0] CH_HEX   = 8'h24; // '$'
	localparam logic [CharW-1:0] CH_MINUS = 8'h2D; // '-'
	localparam logic [CharW-1:0] CH_PLUS  = 8'h2B; // '+'
	localparam logic [CharW-1:0] CH_0     = 8'h30;
	localparam logic [CharW-1:0] CH_9     = 8'h39;
	localparam logic [CharW-1:0] CH_UA    = 8'h41;
	localparam logic [CharW-1:0] CH_UF    = 8'h46;
	localparam logic [CharW-1:0] CH_LA    = 8'h61;
	localparam logic [CharW-1:0] CH_LZ    = 8'h7A;
	localparam logic [CharW-1:0] CASE_OFS = 8'd32;

	// Literal encoding forms
	typedef enum logic [1:0] {
		FORM_SHORT,
		FORM_WORD,
		FORM_LONG
	} form_t;

	// Finished token handed from the parser to the emitter
	typedef struct packed {
		logic [AccW-1:0] acc;
		logic            negative;
		logic            failed;
	} tok_t;

	// Opcode registers
	typedef struct packed {
		logic [7:0] short_op;
		logic [7:0] word_op;
		logic [7:0] long_op;
	} ops_t;

endpackage

// ----- rtl/numeric_literal_encoder_top.sv -----
// Numeric literal encoder top level: stream ports, opcode registers,
// parser and emitter. Depends on nle_pkg, nle_parse, nle_emit.
// Throughput: one character item per cycle; a token yields 1, 2, 3 or 5
// result items at one per cycle while m_tready is high, set by the emitter's byte counter.
// First result item valid in the cycle after the token's last character is taken.
// A last character waits only while the previous token's bytes are going out.
// Reset (arst_n low, async): token state cleared, emitter empty, opcodes 1/2/3.
module numeric_literal_encoder_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // [7:0] token_char
	input  logic                        s_tlast,   // token_end
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [7:0]                  m_tdata,   // [7:0] code_byte
	output logic                        m_tuser,   // [0] parse_failed
	output logic                        m_tlast,   // run_last
	input  logic                        cfg_we,
	input  logic [nle_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [7:0]                  cfg_data
);

	nle_pkg::ops_t ops_q;
	nle_pkg::tok_t tok;
	logic          free;
	logic          s_take;

	// Opcode registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ops_q.short_op <= nle_pkg::SHORT_OP_RST;
			ops_q.word_op  <= nle_pkg::WORD_OP_RST;
			ops_q.long_op  <= nle_pkg::LONG_OP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				nle_pkg::CFG_SHORT_OP: ops_q.short_op <= cfg_data;
				nle_pkg::CFG_WORD_OP:  ops_q.word_op  <= cfg_data;
				nle_pkg::CFG_LONG_OP:  ops_q.long_op  <= cfg_data;
				default: ;
			endcase
		end
	end

	// A last character needs the emitter free; others always pass
	assign s_tready = !s_tlast || free;
	assign s_take   = s_tvalid && s_tready;

	nle_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (s_take),
		.char_in (s_tdata),
		.end_in  (s_tlast),
		.tok     (tok)
	);

	nle_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (s_take && s_tlast),
		.tok      (tok),
		.ops      (ops_q),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// ----- rtl/nle_parse.sv -----
// Token parser: prefix handling, digit decode and accumulation.
// Depends on nle_pkg.
module nle_parse (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      take,      // a character item is accepted
	input  logic [nle_pkg::CharW-1:0] char_in,
	input  logic                      end_in,
	output nle_pkg::tok_t             tok        // token state after this item
);

	logic [nle_pkg::AccW-1:0] acc_q;
	logic hex_q, neg_q, fail_q, start_q;

	logic [nle_pkg::CharW-1:0] uc;
	logic [3:0] dval;
	logic       is_digit;
	logic       do_digit;
	logic       hex_n, neg_n, fail_n;
	logic [nle_pkg::AccW-1:0] acc_n, acc_mul;

	// Case fold and digit decode
	always_comb begin
		uc = char_in;
		if (char_in >= nle_pkg::CH_LA && char_in <= nle_pkg::CH_LZ) begin
			uc = char_in - nle_pkg::CASE_OFS;
		end
		is_digit = 1'b0;
		dval = 4'd0;
		if (uc >= nle_pkg::CH_0 && uc <= nle_pkg::CH_9) begin
			is_digit = 1'b1;
			dval = 4'(uc - nle_pkg::CH_0);
		end else if (hex_q && uc >= nle_pkg::CH_UA && uc <= nle_pkg::CH_UF) begin
			is_digit = 1'b1;
			dval = 4'(uc - nle_pkg::CH_UA + 8'd10);
		end
	end

	// Next token state
	always_comb begin
		hex_n = hex_q;
		neg_n = neg_q;
		fail_n = fail_q;
		acc_n = acc_q;
		do_digit = 1'b1;
		if (start_q) begin
			if (char_in == nle_pkg::CH_HEX) begin
				hex_n = 1'b1;
				do_digit = 1'b0;
			end else if (char_in == nle_pkg::CH_MINUS) begin
				neg_n = 1'b1;
				do_digit = 1'b0;
			end else if (char_in == nle_pkg::CH_PLUS) begin
				do_digit = 1'b0;
			end
		end
		// times 16 or times 10, wrapping
		acc_mul = hex_q ? (acc_q << 4) : ((acc_q << 3) + (acc_q << 1));
		if (do_digit && !fail_q) begin
			if (is_digit) begin
				acc_n = acc_mul + {{(nle_pkg::AccW-4){1'b0}}, dval};
			end else begin
				fail_n = 1'b1;
			end
		end
	end

	assign tok.acc      = acc_n;
	assign tok.negative = neg_n;
	assign tok.failed   = fail_n;

	// Token state registers; cleared at token end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			hex_q   <= 1'b0;
			neg_q   <= 1'b0;
			fail_q  <= 1'b0;
			start_q <= 1'b1;
		end else if (take) begin
			if (end_in) begin
				acc_q   <= '0;
				hex_q   <= 1'b0;
				neg_q   <= 1'b0;
				fail_q  <= 1'b0;
				start_q <= 1'b1;
			end else begin
				acc_q   <= acc_n;
				hex_q   <= hex_n;
				neg_q   <= neg_n;
				fail_q  <= fail_n;
				start_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/nle_emit.sv -----
// Literal emitter: holds one finished token and sends its bytecode bytes.
// Depends on nle_pkg.
module nle_emit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,       // finished token arrives
	input  nle_pkg::tok_t tok,
	input  nle_pkg::ops_t ops,
	output logic          free,       // a token can be loaded this cycle
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [7:0]    m_tdata,    // [7:0] code_byte
	output logic          m_tuser,    // [0] parse_failed
	output logic          m_tlast     // run_last
);

	logic                     pend_q;
	logic [2:0]               idx_q;
	logic [nle_pkg::AccW-1:0] acc_q;
	logic                     neg_q, fail_q;

	logic [nle_pkg::AccW-1:0] v;
	nle_pkg::form_t           form;
	logic [2:0]               n_bytes;
	logic [7:0]               val_byte;
	logic                     m_take;

	// Signed value and encoding form
	always_comb begin
		v = neg_q ? -acc_q : acc_q;
		if (v[31:7] == '0 || v[31:7] == '1) begin
			form = nle_pkg::FORM_SHORT;
		end else if (v[31:16] == '0 || (v[31:16] == '1 && v[15:0] != '0)) begin
			form = nle_pkg::FORM_WORD;
		end else begin
			form = nle_pkg::FORM_LONG;
		end
	end

	// Output byte select
	always_comb begin
		unique case (idx_q)
			3'd1: val_byte = v[7:0];
			3'd2: val_byte = v[15:8];
			3'd3: val_byte = v[23:16];
			3'd4: val_byte = v[31:24];
			default: val_byte = 8'd0;
		endcase
		unique case (form)
			nle_pkg::FORM_SHORT: n_bytes = 3'd1;
			nle_pkg::FORM_WORD:  n_bytes = 3'd2;
			default:             n_bytes = 3'd4;
		endcase
		m_tuser = fail_q;
		if (fail_q) begin
			m_tdata = 8'd0;
			m_tlast = 1'b1;
		end else begin
			m_tlast = (idx_q == n_bytes);
			if (idx_q == 3'd0) begin
				unique case (form)
					nle_pkg::FORM_SHORT: m_tdata = ops.short_op;
					nle_pkg::FORM_WORD:  m_tdata = ops.word_op;
					default:             m_tdata = ops.long_op;
				endcase
			end else begin
				m_tdata = val_byte;
			end
		end
	end

	assign m_tvalid = pend_q;
	assign m_take   = pend_q && m_tready;
	assign free     = !pend_q || (m_take && m_tlast);

	// Control: pending flag and byte index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			idx_q  <= 3'd0;
		end else if (load) begin
			pend_q <= 1'b1;
			idx_q  <= 3'd0;
		end else if (m_take) begin
			if (m_tlast) begin
				pend_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	// Token payload
	always_ff @(posedge clk) begin
		if (load) begin
			acc_q  <= tok.acc;
			neg_q  <= tok.negative;
			fail_q <= tok.failed;
		end
	end

endmodule
